FILE: hdl/greedy_meshlet_builder_macros.svh
// Shared assertion macros.
`ifndef GREEDY_MESHLET_BUILDER_MACROS_SVH
`define GREEDY_MESHLET_BUILDER_MACROS_SVH

// Same-cycle implication.
`define GMB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GMB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/gmb_pkg.sv
package gmb_pkg;

   localparam logic [1:0] KIND_RECORD   = 2'd0;
   localparam logic [1:0] KIND_VERTEX   = 2'd1;
   localparam logic [1:0] KIND_TRIANGLE = 2'd2;

   localparam logic FUNC_END = 1'b1;

   localparam logic [3:0] REG_MAX_VERTS = 4'd0;
   localparam logic [3:0] REG_MAX_TRIS  = 4'd1;
   localparam logic [3:0] REG_CONE_EN   = 4'd2;
   localparam logic [3:0] REG_CONE_COS  = 4'd3;

   localparam int RSP_BITS = 104;

   localparam logic signed [22:0] SUM_MAX = 23'sh3fffff;
   localparam logic signed [22:0] SUM_MIN = 23'sh400000;

   localparam logic [5:0] SH_0  = 6'd0;
   localparam logic [5:0] SH_24 = 6'd24;
   localparam logic [5:0] SH_25 = 6'd25;
   localparam logic [5:0] SH_48 = 6'd48;

   typedef struct packed {
      logic [6:0]  pad;
      logic        normal_valid;
      logic [15:0] normal_z;
      logic [15:0] normal_y;
      logic [15:0] normal_x;
      logic [23:0] vert_c;
      logic [23:0] vert_b;
      logic [23:0] vert_a;
   } req_data_type;

   typedef struct packed {
      logic [6:0]  mesh_triangle_count;
      logic [6:0]  mesh_vertex_count;
      logic [23:0] mesh_triangle_offset;
      logic [23:0] mesh_vertex_offset;
      logic [5:0]  local_c;
      logic [5:0]  local_b;
      logic [5:0]  local_a;
      logic [23:0] global_vertex;
   } rsp_data_type;

   typedef struct packed {
      logic               clr;
      logic signed [24:0] a;
      logic signed [24:0] b;
      logic [5:0]         sh;
   } mac_cmd_type;

endpackage

FILE: hdl/gmb_vtab.sv
module gmb_vtab #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [23:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [23:0]   rd_data
);
   logic [23:0] mem [DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/gmb_mac.sv
module gmb_mac (
   input  logic                clock,
   input  logic                en,
   input  gmb_pkg::mac_cmd_type cmd,
   output logic signed [79:0]  acc
);
   import gmb_pkg::*;

   logic signed [49:0] prod;
   logic signed [79:0] term;
   logic signed [79:0] acc_ff;
   logic signed [79:0] acc_in;

   always_comb begin
      prod   = cmd.a * cmd.b;
      term   = 80'(prod) <<< cmd.sh;
      acc_in = (cmd.clr ? '0 : acc_ff) + term;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
endmodule

FILE: hdl/greedy_meshlet_builder.sv
// Sequence: a triangle is accepted, then searched against the vertex table (no search when the
// meshlet is empty), run through the multiply-accumulate cone test when that test applies,
// then close decision, three vertex slots, triangle entry; output stalls can hold these steps.
// Throughput: one item at a time; an end item can also be held by an output stall.
// Reset (synchronous, active high) restores register defaults and clears counts, sums, totals.
module greedy_meshlet_builder #(
   parameter int TABLE_DEPTH = 64,
   parameter int TRI_CAP     = 124,
   parameter int INDEX_BITS  = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vert_a, vert_b, vert_c, normal_x, normal_y, normal_z, normal_valid, zero pad
   input  logic [127:0] req_tdata,
   // func
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // global_vertex, local_a, local_b, local_c, mesh_vertex_offset,
   // mesh_triangle_offset, mesh_vertex_count, mesh_triangle_count
   output logic [103:0] rsp_tdata,
   // kind
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [14:0]  csr_data
);
   import gmb_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_CONE, S_DECIDE, S_VERT, S_TRI, S_END
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]  mv_ff, mt_ff;
   logic        ce_ff;
   logic [14:0] cos_ff;

   logic [6:0] cnt_ff, cnt_in, tri_ff, tri_in;
   logic signed [22:0] sum_ff [3];
   logic signed [22:0] sum_in [3];
   logic [INDEX_BITS-1:0] vtot_ff, vtot_in, ttot_ff, ttot_in;

   logic [23:0] g_ff [3];
   logic [23:0] g_in [3];
   logic signed [15:0] n_ff [3];
   logic signed [15:0] n_in [3];
   logic nv_ff, nv_in;
   logic [AW-1:0] loc_ff [3];
   logic [AW-1:0] loc_in [3];
   logic [2:0] found_ff, found_in, newf_ff, newf_in;
   logic [1:0] j_ff, j_in;
   logic [6:0] srch_ff, srch_in;
   logic pend_ff, pend_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic [3:0] step_ff, step_in;
   logic cone_on_ff, cone_on_in;
   logic signed [39:0] dot_ff, dot_in;
   logic [45:0] s2_ff, s2_in;
   logic [29:0] c2_ff, c2_in;
   logic [79:0] dsq_ff, dsq_in;

   logic rv_ff, rv_in, rl_ff, rl_in;
   logic [1:0] rk_ff, rk_in;
   rsp_data_type rd_ff, rd_in;

   req_data_type req;
   logic signed [79:0] acc;
   mac_cmd_type cmd;
   logic mac_en;
   logic [23:0] tab_rd;
   logic tab_we;
   logic [AW-1:0] tab_wa;
   logic [23:0] tab_wd;

   logic slot_free;
   logic [6:0] vmax;
   logic [7:0] tmax;
   logic [1:0] added;
   logic close;
   logic [INDEX_BITS-1:0] voff, toff;
   rsp_data_type rec;
   logic [23:0] gj;
   logic dup;
   logic [AW-1:0] dup_loc;
   logic signed [23:0] sat_sum [3];

   assign req        = req_data_type'(req_tdata);
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = RSP_BITS'(rd_ff);
   assign rsp_tuser  = rk_ff;
   assign rsp_tlast  = rl_ff;
   assign slot_free  = !rv_ff || rsp_tready;

   gmb_vtab #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_vtab (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_wa),
      .wr_data (tab_wd),
      .rd_addr (srch_ff[AW-1:0]),
      .rd_data (tab_rd)
   );

   gmb_mac u_mac (
      .clock (clock),
      .en    (mac_en),
      .cmd   (cmd),
      .acc   (acc)
   );

   // cone micro-sequence operands
   always_comb begin
      cmd = '{clr: 1'b0, a: '0, b: '0, sh: SH_0};
      unique case (step_ff)
         4'd0:  cmd = '{1'b1, 25'(n_ff[0]), 25'(sum_ff[0]), SH_0};
         4'd1:  cmd = '{1'b0, 25'(n_ff[1]), 25'(sum_ff[1]), SH_0};
         4'd2:  cmd = '{1'b0, 25'(n_ff[2]), 25'(sum_ff[2]), SH_0};
         4'd3:  cmd = '{1'b1, 25'(sum_ff[0]), 25'(sum_ff[0]), SH_0};
         4'd4:  cmd = '{1'b0, 25'(sum_ff[1]), 25'(sum_ff[1]), SH_0};
         4'd5:  cmd = '{1'b0, 25'(sum_ff[2]), 25'(sum_ff[2]), SH_0};
         4'd6:  cmd = '{1'b1, $signed({10'd0, cos_ff}), $signed({10'd0, cos_ff}), SH_0};
         4'd7:  cmd = '{1'b1, $signed({1'b0, dot_ff[23:0]}), $signed({1'b0, dot_ff[23:0]}),
                       SH_0};
         4'd8:  cmd = '{1'b0, $signed({1'b0, dot_ff[23:0]}), $signed({10'd0, dot_ff[38:24]}),
                       SH_25};
         4'd9:  cmd = '{1'b0, $signed({10'd0, dot_ff[38:24]}), $signed({10'd0, dot_ff[38:24]}),
                       SH_48};
         4'd10: cmd = '{1'b1, $signed({1'b0, c2_ff[23:0]}), $signed({1'b0, s2_ff[23:0]}), SH_0};
         4'd11: cmd = '{1'b0, $signed({1'b0, c2_ff[23:0]}), $signed({3'd0, s2_ff[45:24]}),
                       SH_24};
         4'd12: cmd = '{1'b0, $signed({19'd0, c2_ff[29:24]}), $signed({1'b0, s2_ff[23:0]}),
                       SH_24};
         4'd13: cmd = '{1'b0, $signed({19'd0, c2_ff[29:24]}), $signed({3'd0, s2_ff[45:24]}),
                       SH_48};
         default: cmd = '{clr: 1'b0, a: '0, b: '0, sh: SH_0};
      endcase
   end

   assign mac_en = (state_ff == S_CONE);

   always_comb begin
      vmax = mv_ff;
      if (mv_ff < 7'd3) begin
         vmax = 7'd3;
      end else if (mv_ff > 7'(TABLE_DEPTH)) begin
         vmax = 7'(TABLE_DEPTH);
      end
      tmax  = (8'(mt_ff) < 8'(TRI_CAP)) ? 8'(mt_ff) : 8'(TRI_CAP);
      added = 2'(!found_ff[0]) + 2'(!found_ff[1]) + 2'(!found_ff[2]);
      close = (8'(cnt_ff) + 8'(added) > 8'(vmax)) || (8'(tri_ff) >= tmax) ||
              (cone_on_ff && (dot_ff < 0 || dsq_ff < 80'(acc)));
      voff  = vtot_ff - INDEX_BITS'(cnt_ff);
      toff  = ttot_ff - INDEX_BITS'(tri_ff);
      rec   = '0;
      rec.mesh_vertex_offset   = 24'(32'(voff));
      rec.mesh_triangle_offset = 24'(32'(toff));
      rec.mesh_vertex_count    = cnt_ff;
      rec.mesh_triangle_count  = tri_ff;
      gj      = g_ff[j_ff];
      dup     = 1'b0;
      dup_loc = '0;
      for (int i = 1; i >= 0; i--) begin
         if (i < int'(j_ff) && newf_ff[i] && g_ff[i] == gj) begin
            dup     = 1'b1;
            dup_loc = loc_ff[i];
         end
      end
      for (int k = 0; k < 3; k++) begin
         sat_sum[k] = (close ? 24'sd0 : 24'(sum_ff[k])) + 24'(n_ff[k]);
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; tri_in = tri_ff; vtot_in = vtot_ff; ttot_in = ttot_ff;
      sum_in = sum_ff; g_in = g_ff; n_in = n_ff; nv_in = nv_ff; loc_in = loc_ff;
      found_in = found_ff; newf_in = newf_ff; j_in = j_ff; srch_in = srch_ff;
      pend_in = 1'b0; pidx_in = pidx_ff; step_in = step_ff; cone_on_in = cone_on_ff;
      dot_in = dot_ff; s2_in = s2_ff; c2_in = c2_ff; dsq_in = dsq_ff;
      rv_in = rv_ff && !rsp_tready; rk_in = rk_ff; rl_in = rl_ff; rd_in = rd_ff;
      tab_we = 1'b0; tab_wa = cnt_ff[AW-1:0]; tab_wd = gj;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               g_in[0] = req.vert_a; g_in[1] = req.vert_b; g_in[2] = req.vert_c;
               n_in[0] = req.normal_x; n_in[1] = req.normal_y; n_in[2] = req.normal_z;
               nv_in = req.normal_valid;
               found_in = '0; newf_in = '0; srch_in = '0;
               state_in = (req_tuser == FUNC_END) ? S_END : S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (pend_ff) begin
               for (int k = 0; k < 3; k++) begin
                  if (!found_ff[k] && tab_rd == g_ff[k]) begin
                     found_in[k] = 1'b1;
                     loc_in[k]   = pidx_ff;
                  end
               end
            end
            if (srch_ff < cnt_ff) begin
               pend_in = 1'b1;
               pidx_in = srch_ff[AW-1:0];
               srch_in = srch_ff + 7'd1;
            end else if (!pend_ff) begin
               cone_on_in = ce_ff && cnt_ff != 7'd0 &&
                            (sum_ff[0] != 0 || sum_ff[1] != 0 || sum_ff[2] != 0);
               step_in  = '0;
               state_in = cone_on_in ? S_CONE : S_DECIDE;
            end
         end
         S_CONE: begin
            // no normal: dot product counts as zero
            if (step_ff == 4'd3) dot_in = nv_ff ? 40'(acc) : '0;
            if (step_ff == 4'd6) s2_in = 46'(acc);
            if (step_ff == 4'd7) c2_in = 30'(acc);
            if (step_ff == 4'd10) dsq_in = 80'(acc);
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd13) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!(close && cnt_ff != 7'd0) || slot_free) begin
               if (close) begin
                  if (cnt_ff != 7'd0) begin
                     rv_in = 1'b1; rk_in = KIND_RECORD; rl_in = 1'b0; rd_in = rec;
                  end
                  cnt_in = '0; tri_in = '0; found_in = '0;
                  sum_in = '{default: '0};
               end
               if (nv_ff) begin
                  for (int k = 0; k < 3; k++) begin
                     if (sat_sum[k] > 24'(SUM_MAX)) sum_in[k] = SUM_MAX;
                     else if (sat_sum[k] < 24'(SUM_MIN)) sum_in[k] = SUM_MIN;
                     else sum_in[k] = 23'(sat_sum[k]);
                  end
               end
               j_in = '0;
               state_in = S_VERT;
            end
         end
         S_VERT: begin
            if (dup || found_ff[j_ff]) begin
               if (dup) loc_in[j_ff] = dup_loc;
               j_in = j_ff + 2'd1;
               if (j_ff == 2'd2) state_in = S_TRI;
            end else if (slot_free) begin
               tab_we = 1'b1;
               loc_in[j_ff] = cnt_ff[AW-1:0];
               newf_in[j_ff] = 1'b1;
               cnt_in  = cnt_ff + 7'd1;
               vtot_in = vtot_ff + INDEX_BITS'(1);
               rv_in = 1'b1; rk_in = KIND_VERTEX; rl_in = 1'b0;
               rd_in = '0; rd_in.global_vertex = gj;
               j_in = j_ff + 2'd1;
               if (j_ff == 2'd2) state_in = S_TRI;
            end
         end
         S_TRI: begin
            if (slot_free) begin
               rv_in = 1'b1; rk_in = KIND_TRIANGLE; rl_in = 1'b1;
               rd_in = '0;
               rd_in.local_a = 6'(loc_ff[0]);
               rd_in.local_b = 6'(loc_ff[1]);
               rd_in.local_c = 6'(loc_ff[2]);
               tri_in  = tri_ff + 7'd1;
               ttot_in = ttot_ff + INDEX_BITS'(1);
               state_in = S_IDLE;
            end
         end
         S_END: begin
            if (cnt_ff == 7'd0 || slot_free) begin
               if (cnt_ff != 7'd0) begin
                  rv_in = 1'b1; rk_in = KIND_RECORD; rl_in = 1'b1; rd_in = rec;
               end
               cnt_in = '0; tri_in = '0; vtot_in = '0; ttot_in = '0;
               sum_in = '{default: '0};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mv_ff <= 7'd64; mt_ff <= 7'd124; ce_ff <= 1'b1; cos_ff <= 15'd13926;
         cnt_ff <= '0; tri_ff <= '0; vtot_ff <= '0; ttot_ff <= '0;
         sum_ff <= '{default: '0};
         pend_ff <= 1'b0; rv_ff <= 1'b0; cone_on_ff <= 1'b0; step_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in; tri_ff <= tri_in; vtot_ff <= vtot_in; ttot_ff <= ttot_in;
         sum_ff <= sum_in;
         pend_ff <= pend_in; rv_ff <= rv_in; cone_on_ff <= cone_on_in; step_ff <= step_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_MAX_VERTS: mv_ff  <= csr_data[6:0];
               REG_MAX_TRIS:  mt_ff  <= csr_data[6:0];
               REG_CONE_EN:   ce_ff  <= csr_data[0];
               REG_CONE_COS:  cos_ff <= csr_data;
               default: ;
            endcase
         end
      end
      g_ff <= g_in; n_ff <= n_in; nv_ff <= nv_in; loc_ff <= loc_in;
      found_ff <= found_in; newf_ff <= newf_in; j_ff <= j_in; srch_ff <= srch_in;
      pidx_ff <= pidx_in; dot_ff <= dot_in; s2_ff <= s2_in; c2_ff <= c2_in;
      dsq_ff <= dsq_in; rk_ff <= rk_in; rl_ff <= rl_in; rd_ff <= rd_in;
   end

`include "greedy_meshlet_builder_macros.svh"

   `GMB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= 7'(TABLE_DEPTH), "vertex count over table depth")
   `GMB_ASSERT_NOW(a_tri_last, rv_ff && rk_ff == KIND_TRIANGLE, rl_ff, "triangle entry not last")
   `GMB_ASSERT_NEXT(a_busy, req_tvalid && req_tready, !req_tready, "item taken while busy")
   `GMB_ASSERT_NOW(a_cone_gate, state_ff == S_CONE, cone_on_ff, "cone unit run without cone test")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import gmb_pkg::*;

   typedef struct {
      logic         func;
      req_data_type d;
   } tri_item_type;

   typedef struct {
      logic [1:0]   kind;
      rsp_data_type d;
      logic         last;
   } out_entry_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [3:0]   csr_index = '0;
   logic [14:0]  csr_data = '0;

   greedy_meshlet_builder dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tri_item_type  pending_items[$];
   out_entry_type expected_out[$];
   int            mismatches = 0;

   // mirror of the block
   logic [6:0]  budget_verts, budget_tris;
   logic        cone_en;
   logic [14:0] cone_cos;
   logic [23:0] vtab[64];
   int          nverts, ntris;
   int          sum_x, sum_y, sum_z;
   logic [23:0] vert_total, tri_running;

   function automatic int find_vertex(logic [23:0] g);
      for (int i = 0; i < nverts; i++)
         if (vtab[i] == g) return i;
      return -1;
   endfunction

   function automatic int sat_sum(int s, int d);
      int r;
      r = s + d;
      if (r > 4194303) r = 4194303;
      if (r < -4194304) r = -4194304;
      return r;
   endfunction

   function automatic void push_out(logic [1:0] kind, rsp_data_type d, logic last);
      out_entry_type e;
      e.kind = kind;
      e.d = d;
      e.last = last;
      expected_out.insert(expected_out.size(), e);
   endfunction

   function automatic void close_meshlet(logic last);
      rsp_data_type d;
      if (nverts == 0) return;
      d = '0;
      d.mesh_vertex_offset = vert_total - 24'(nverts);
      d.mesh_triangle_offset = tri_running - 24'(ntris);
      d.mesh_vertex_count = 7'(nverts);
      d.mesh_triangle_count = 7'(ntris);
      push_out(KIND_RECORD, d, last);
      nverts = 0;
      ntris = 0;
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
   endfunction

   function automatic logic cone_breaks(int nx, int ny, int nz, logic valid);
      longint      dot;
      logic [127:0] dd, rr, s2, c2;
      if (!cone_en || nverts == 0) return 1'b0;
      if (sum_x == 0 && sum_y == 0 && sum_z == 0) return 1'b0;
      dot = valid ? longint'(nx) * sum_x + longint'(ny) * sum_y + longint'(nz) * sum_z : 0;
      if (dot < 0) return 1'b1;
      dd = 128'(dot) * 128'(dot);
      s2 = 128'(longint'(sum_x) * sum_x) + 128'(longint'(sum_y) * sum_y)
         + 128'(longint'(sum_z) * sum_z);
      c2 = 128'(cone_cos) * 128'(cone_cos);
      rr = c2 * s2;
      return dd < rr;
   endfunction

   function automatic void build_meshlet(logic func, req_data_type q);
      logic [23:0]  g[3];
      int           nx, ny, nz, vmax, tmax, added, idx;
      int           loc[3];
      rsp_data_type d;
      if (func == FUNC_END) begin
         close_meshlet(1'b1);
         vert_total = '0;
         tri_running = '0;
         return;
      end
      g[0] = q.vert_a;
      g[1] = q.vert_b;
      g[2] = q.vert_c;
      nx = int'($signed(q.normal_x));
      ny = int'($signed(q.normal_y));
      nz = int'($signed(q.normal_z));
      vmax = int'(budget_verts);
      if (vmax < 3) vmax = 3;
      if (vmax > 64) vmax = 64;
      tmax = int'(budget_tris) < 124 ? int'(budget_tris) : 124;
      added = 0;
      for (int j = 0; j < 3; j++)
         if (find_vertex(g[j]) < 0) added++;
      if (nverts + added > vmax || ntris >= tmax || cone_breaks(nx, ny, nz, q.normal_valid))
         close_meshlet(1'b0);
      if (q.normal_valid) begin
         sum_x = sat_sum(sum_x, nx);
         sum_y = sat_sum(sum_y, ny);
         sum_z = sat_sum(sum_z, nz);
      end
      for (int j = 0; j < 3; j++) begin
         idx = find_vertex(g[j]);
         if (idx < 0 && nverts < 64) begin
            idx = nverts;
            vtab[nverts] = g[j];
            nverts++;
            vert_total = vert_total + 24'd1;
            d = '0;
            d.global_vertex = g[j];
            push_out(KIND_VERTEX, d, 1'b0);
         end
         loc[j] = idx < 0 ? 0 : idx;
      end
      d = '0;
      d.local_a = 6'(loc[0]);
      d.local_b = 6'(loc[1]);
      d.local_c = 6'(loc[2]);
      push_out(KIND_TRIANGLE, d, 1'b1);
      ntris = (ntris + 1) & 32'h7f;
      tri_running = tri_running + 24'd1;
   endfunction

   // driver: bursts with gaps
   logic req_fire = 1'b0;
   int   burst_left = 0;
   int   gap_left = 0;

   always @(negedge clock) begin
      tri_item_type it;
      if (!reset && (!req_tvalid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= it.d;
            req_tuser <= it.func;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   int stall_mode = 0;
   int mode_left = 0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(10, 80);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // monitor
   always @(posedge clock) begin
      out_entry_type e;
      req_fire <= req_tvalid && req_tready;
      if (reset) begin
         budget_verts = 7'd64;
         budget_tris = 7'd124;
         cone_en = 1'b1;
         cone_cos = 15'd13926;
         nverts = 0;
         ntris = 0;
         sum_x = 0;
         sum_y = 0;
         sum_z = 0;
         vert_total = '0;
         tri_running = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAX_VERTS: budget_verts = csr_data[6:0];
               REG_MAX_TRIS:  budget_tris = csr_data[6:0];
               REG_CONE_EN:   cone_en = csr_data[0];
               REG_CONE_COS:  cone_cos = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            build_meshlet(req_tuser, req_data_type'(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_out.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transfer kind=%0d data=%h last=%b",
                           rsp_tuser, rsp_tdata, rsp_tlast);
            end else begin
               e = expected_out.pop_front();
               if (rsp_tuser !== e.kind || rsp_tdata !== e.d || rsp_tlast !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp kind=%0d data=%h last=%b, got kind=%0d data=%h last=%b",
                              e.kind, e.d, e.last, rsp_tuser, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
   end

   task automatic push_tri(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                           int nx, int ny, int nz, logic valid);
      tri_item_type it;
      it.func = 1'b0;
      it.d = '0;
      it.d.vert_a = a;
      it.d.vert_b = b;
      it.d.vert_c = c;
      it.d.normal_x = 16'(nx);
      it.d.normal_y = 16'(ny);
      it.d.normal_z = 16'(nz);
      it.d.normal_valid = valid;
      pending_items.insert(pending_items.size(), it);
   endtask

   task automatic push_end();
      tri_item_type it;
      it.func = FUNC_END;
      it.d = '0;
      pending_items.insert(pending_items.size(), it);
   endtask

   task automatic write_reg(logic [3:0] idx, logic [14:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(int mv, int mt, int en, int cs);
      write_reg(REG_MAX_VERTS, 15'(mv));
      write_reg(REG_MAX_TRIS, 15'(mt));
      write_reg(REG_CONE_EN, 15'(en));
      write_reg(REG_CONE_COS, 15'(cs));
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_items.size() > 0 || req_tvalid || expected_out.size() > 0);
      repeat (150) @(posedge clock);
   endtask

   task automatic push_random(int n);
      int          axis, sgn, r, main_c, o1, o2;
      logic [23:0] base;
      int          comp[3];
      base = 24'($urandom);
      axis = 0;
      sgn = 1;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            push_end();
         end else if (r < 13) begin
            push_tri(24'($urandom), 24'($urandom), 24'($urandom),
                     $urandom_range(0, 32768) - 16384,
                     $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                     1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 9) == 0) axis = $urandom_range(0, 2);
            if ($urandom_range(0, 14) == 0) sgn = -sgn;
            if ($urandom_range(0, 5) == 0) base = base + 24'($urandom_range(1, 40));
            main_c = sgn * (16384 - $urandom_range(0, 4000));
            o1 = $urandom_range(0, 6000) - 3000;
            o2 = $urandom_range(0, 6000) - 3000;
            comp[axis] = main_c;
            comp[(axis + 1) % 3] = o1;
            comp[(axis + 2) % 3] = o2;
            push_tri(base + 24'($urandom_range(0, 30)), base + 24'($urandom_range(0, 30)),
                     base + 24'($urandom_range(0, 30)), comp[0], comp[1], comp[2],
                     $urandom_range(0, 9) != 0);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: defaults first
      push_tri(24'd0, 24'd1, 24'd2, 16384, 0, 0, 1'b1);
      push_tri(24'd1, 24'd2, 24'd3, 16384, 0, 0, 1'b1);
      push_tri(24'hffffff, 24'hffffff, 24'd1, 0, 16384, 0, 1'b1);
      push_tri(24'h555555, 24'haaaaaa, 24'd2, -16384, 0, 0, 1'b1);
      push_tri(24'd7, 24'd8, 24'd9, 0, 0, 0, 1'b0);
      push_tri(24'd7, 24'd8, 24'd10, 0, 0, -16384, 1'b1);
      push_tri(24'd7, 24'd7, 24'd7, -1, -1, -1, 1'b1);
      push_end();
      push_end();
      for (int i = 0; i < 24; i++)
         push_tri(24'(3 * i), 24'(3 * i + 1), 24'(3 * i + 2), 16384, 16384, 16384, 1'b1);
      push_tri(24'd500, 24'd501, 24'd502, 16384, 16384, 16384, 1'b1);
      push_end();
      drain();

      set_regs(3, 1, 0, 0);
      push_tri(24'd1, 24'd2, 24'd3, 0, 0, 0, 1'b0);
      push_tri(24'd1, 24'd2, 24'd3, 0, 0, 0, 1'b0);
      push_random(40);
      drain();

      set_regs(0, 0, 1, 32767);
      push_random(45);
      drain();

      set_regs(127, 127, 1, 16384);
      push_random(45);
      drain();

      set_regs(10, 5, 1, 8000);
      push_random(45);
      drain();

      set_regs(64, 124, 1, 0);
      push_random(45);
      push_end();
      drain();

      if (mismatches == 0 && expected_out.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/gmb_pkg.sv
hdl/gmb_vtab.sv
hdl/gmb_mac.sv
hdl/greedy_meshlet_builder.sv
bench/tb_top.sv
